### design/rasr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rasr_pkg;

  typedef struct packed {
    logic signed [15:0] spin_x;
    logic signed [15:0] spin_y;
    logic signed [15:0] spin_z;
    logic signed [15:0] axis_cos;
    logic        [15:0] axis_azimuth;
    logic        [15:0] angle_fraction;
  } rasr_in_t;

  typedef struct packed {
    logic signed [15:0] rotated_x;
    logic signed [15:0] rotated_y;
    logic signed [15:0] rotated_z;
  } rasr_out_t;

  // 1.0 and half an LSB of the Q2.30 angle and series format
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [31:0] RND_Q30 = 32'h2000_0000;

endpackage

`default_nettype wire

### design/rasr_horner.sv
`timescale 1ns / 1ps
`default_nettype none

// One Horner step t' = 1 - floor(round(x2 * t) / DIV), four register stages.
module rasr_horner #(
  parameter int DIV = 2
) (
  input  logic        clk,
  input  logic [31:0] x2,
  input  logic [30:0] t_in,
  output logic [30:0] t_out
);
  import rasr_pkg::*;

  // exact reciprocal for any 32-bit dividend: floor(n * RECIP / 2^SH) == floor(n / DIV)
  localparam int          SH    = 32 + $clog2(DIV);
  localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);

  logic [62:0] prod;
  logic [62:0] prod_rnd;
  logic [31:0] part;
  logic [65:0] scaled;
  logic [65:0] scaled_sh;
  logic [31:0] quo;

  assign prod_rnd  = prod + {31'd0, RND_Q30};
  assign scaled_sh = scaled >> SH;
  assign quo       = scaled_sh[31:0];

  always_ff @(posedge clk) begin
    prod   <= x2 * t_in;
    part   <= prod_rnd[61:30];
    scaled <= part * RECIP[33:0];
    // clamp at zero when the quotient reaches one
    t_out  <= (quo >= {1'b0, ONE_Q30}) ? '0 : ONE_Q30 - quo[30:0];
  end

endmodule

`default_nettype wire

### design/rasr_sincos.sv
`timescale 1ns / 1ps
`default_nettype none

// Sine and cosine of a Q2.30 angle in [0, pi/2) by Horner-form series.
module rasr_sincos (
  input  logic        clk,
  input  logic [30:0] angle,
  output logic [31:0] sin_val,
  output logic [30:0] cos_val
);
  import rasr_pkg::*;

  localparam int NSIN     = 5;
  localparam int NCOS     = 6;
  localparam int STEP_LAT = 4;
  localparam int X2_TAPS  = STEP_LAT * (NCOS - 1);
  localparam int X_DLY    = STEP_LAT * NSIN;

  function automatic int sin_div(input int i);
    int d;
    case (i)
      0:       d = 110;
      1:       d = 72;
      2:       d = 42;
      3:       d = 20;
      default: d = 6;
    endcase
    return d;
  endfunction

  function automatic int cos_div(input int i);
    int d;
    case (i)
      0:       d = 132;
      1:       d = 90;
      2:       d = 56;
      3:       d = 30;
      4:       d = 12;
      default: d = 2;
    endcase
    return d;
  endfunction

  logic [61:0] xsq;
  logic [61:0] xsq_rnd;
  logic [30:0] x_1;
  logic [31:0] x2_d [0:X2_TAPS];
  logic [30:0] x_d  [0:X_DLY];
  logic [30:0] sin_ch [0:NSIN];
  logic [30:0] cos_ch [0:NCOS];
  logic [61:0] sprod;
  logic [61:0] sprod_rnd;
  logic [31:0] sin_1;
  logic [31:0] sin_2;

  assign xsq_rnd   = xsq + {30'd0, RND_Q30};
  assign sprod_rnd = sprod + {30'd0, RND_Q30};

  always_ff @(posedge clk) begin
    xsq     <= angle * angle;
    x_1     <= angle;
    x2_d[0] <= xsq_rnd[61:30];
    x_d[0]  <= x_1;
    for (int i = 1; i <= X2_TAPS; i++) x2_d[i] <= x2_d[i-1];
    for (int i = 1; i <= X_DLY; i++) x_d[i] <= x_d[i-1];
  end

  assign sin_ch[0] = ONE_Q30;
  assign cos_ch[0] = ONE_Q30;

  for (genvar i = 0; i < NSIN; i++) begin : g_sin
    rasr_horner #(.DIV(sin_div(i))) u_step (
      .clk   (clk),
      .x2    (x2_d[STEP_LAT*i]),
      .t_in  (sin_ch[i]),
      .t_out (sin_ch[i+1])
    );
  end

  for (genvar i = 0; i < NCOS; i++) begin : g_cos
    rasr_horner #(.DIV(cos_div(i))) u_step (
      .clk   (clk),
      .x2    (x2_d[STEP_LAT*i]),
      .t_in  (cos_ch[i]),
      .t_out (cos_ch[i+1])
    );
  end

  // finish the sine with x * t, then pad to the cosine's depth
  always_ff @(posedge clk) begin
    sprod   <= x_d[X_DLY] * sin_ch[NSIN];
    sin_1   <= sprod_rnd[61:30];
    sin_2   <= sin_1;
    sin_val <= sin_2;
  end

  assign cos_val = cos_ch[NCOS];

endmodule

`default_nettype wire

### design/random_axis_spin_rotation_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                     Handshake
// input     item (rasr_in_t)          taken when start is high and busy is low
// result    result (rasr_out_t)       valid for one cycle while done is high
// config    cfg_data [15:0]           max_angle written when cfg_we is high
//
// Fully pipelined: one item per cycle.
// Depth is set by the two sine/cosine units (six Horner steps of four stages).
// rst clears the valid pipeline and loads max_angle with 2621.
// busy stays low; nothing stalls and the receiver cannot hold results off.
module random_axis_spin_rotation_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  rasr_pkg::rasr_in_t  item,
  output logic                done,
  output rasr_pkg::rasr_out_t result,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data
);
  import rasr_pkg::*;

  typedef enum logic [1:0] {QUAD_1, QUAD_2, QUAD_3, QUAD_4} quad_t;

  localparam int                 NSTG            = 39;
  localparam int                 SQ_BITS         = 15;
  localparam int                 SQ_STG          = 8;
  localparam logic [30:0]        HALF_PI_Q30     = 31'd1686629713;
  localparam logic [15:0]        MAX_ANGLE_RESET = 16'd2621;
  localparam logic signed [15:0] COS_LIM         = 16'sd16384;
  localparam logic [28:0]        SQ_TOP          = 29'h1000_0000;
  localparam logic signed [71:0] SAT_HI          = 72'sd32767;
  localparam logic signed [71:0] SAT_LO          = -72'sd32768;

  // divide by 2^n, rounding half away from zero
  function automatic logic signed [71:0] round_shift(input logic signed [71:0] v,
                                                     input int unsigned n);
    logic signed [71:0] h;
    logic signed [71:0] tmp;
    h   = 72'sd1 <<< (n - 1);
    tmp = v + h - $signed({71'd0, v[71]});
    return tmp >>> n;
  endfunction

  logic [15:0]       max_angle;
  logic [NSTG:1]     vld;

  logic signed [15:0] u_in;
  logic signed [15:0] sp_st  [1:33][3];
  logic signed [15:0] u_st   [1:29];
  quad_t              quad_st[1:28];
  logic [15:0]        az_1;
  logic [15:0]        frac_1;

  logic [44:0]        azp;
  logic [31:0]        angp;
  logic signed [31:0] usq;
  logic [30:0]        xa_2;
  logic [30:0]        alpha_2;
  logic [28:0]        usq_2;

  logic [30:0]        sq_rem  [0:SQ_STG];
  logic [14:0]        sq_root [0:SQ_STG];
  logic [14:0]        sint_st [12:28];

  logic [31:0]        ps;
  logic [30:0]        pc;
  logic [31:0]        sa;
  logic [30:0]        ca;

  logic signed [32:0] ps_s;
  logic signed [32:0] pc_s;
  logic signed [32:0] cphi;
  logic signed [32:0] sphi;
  logic signed [48:0] kxp;
  logic signed [48:0] kyp;
  logic signed [71:0] kx_r;
  logic signed [71:0] ky_r;
  logic [31:0]        sa_st  [29:33];
  logic [30:0]        ca_st  [29:33];
  logic [30:0]        omc_st [29:35];

  logic signed [31:0] k_st   [30:33][3];
  logic signed [47:0] kp     [3][3];
  logic signed [49:0] dsum;
  logic signed [49:0] cs     [3];
  logic signed [71:0] dot_r;
  logic signed [71:0] cr_r   [3];
  logic signed [33:0] dot_33;
  logic signed [33:0] cr_33  [3];

  logic signed [47:0] t1_st  [34:37][3];
  logic signed [66:0] t2p    [3];
  logic signed [65:0] kdp    [3];
  logic signed [71:0] t2_r   [3];
  logic signed [71:0] kd_r   [3];
  logic signed [49:0] t2_st  [35:37][3];
  logic signed [33:0] kd_35  [3];
  logic signed [65:0] t3p    [3];
  logic signed [71:0] t3_r   [3];
  logic signed [49:0] t3_37  [3];
  logic signed [51:0] sum_38 [3];
  logic signed [71:0] fin_r  [3];
  logic signed [15:0] sat_v  [3];

  assign busy = 1'b0;
  assign done = vld[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      max_angle <= MAX_ANGLE_RESET;
    end else if (cfg_we) begin
      max_angle <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NSTG-1:1], start & ~busy};
    end
  end

  // stage 1: capture the item, clamp the axis cosine to [-1, 1]
  always_comb begin
    if ($signed(item.axis_cos) > COS_LIM) begin
      u_in = COS_LIM;
    end else if ($signed(item.axis_cos) < -COS_LIM) begin
      u_in = -COS_LIM;
    end else begin
      u_in = item.axis_cos;
    end
  end

  always_ff @(posedge clk) begin
    sp_st[1][0] <= item.spin_x;
    sp_st[1][1] <= item.spin_y;
    sp_st[1][2] <= item.spin_z;
    u_st[1]     <= u_in;
    quad_st[1]  <= quad_t'(item.axis_azimuth[15:14]);
    az_1        <= item.axis_azimuth;
    frac_1      <= item.angle_fraction;
    for (int i = 2; i <= 33; i++) sp_st[i] <= sp_st[i-1];
    for (int i = 2; i <= 29; i++) u_st[i] <= u_st[i-1];
    for (int i = 2; i <= 28; i++) quad_st[i] <= quad_st[i-1];
  end

  // stage 2: azimuth within its quadrant, rotation angle, u^2
  assign azp  = az_1[13:0] * HALF_PI_Q30;
  assign angp = max_angle * frac_1;
  assign usq  = u_st[1] * u_st[1];

  always_ff @(posedge clk) begin
    xa_2    <= azp[44:14];
    alpha_2 <= {1'b0, angp[31:2]};
    usq_2   <= usq[28:0];
  end

  // stages 3..11: polar sine as floor(sqrt(1 - u^2)), two root bits a stage (one in the last)
  always_ff @(posedge clk) begin
    sq_rem[0]  <= {2'b00, SQ_TOP - usq_2};
    sq_root[0] <= '0;
  end

  for (genvar j = 0; j < SQ_STG; j++) begin : g_sqrt
    logic [30:0] rem_w;
    logic [14:0] root_w;
    logic [30:0] trial;

    always_comb begin
      rem_w  = sq_rem[j];
      root_w = sq_root[j];
      trial  = '0;
      for (int k = 0; k < 2; k++) begin
        if (2 * j + k < SQ_BITS) begin
          trial = (31'(root_w) << (SQ_BITS - 2 * j - k))
                | (31'd1 << (2 * (SQ_BITS - 1 - 2 * j - k)));
          if (rem_w >= trial) begin
            rem_w  = rem_w - trial;
            root_w = root_w | (15'd1 << (SQ_BITS - 1 - 2 * j - k));
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      sq_rem[j+1]  <= rem_w;
      sq_root[j+1] <= root_w;
    end
  end

  always_ff @(posedge clk) begin
    sint_st[12] <= sq_root[SQ_STG];
    for (int i = 13; i <= 28; i++) sint_st[i] <= sint_st[i-1];
  end

  // stages 3..28: sine and cosine of azimuth and rotation angle
  rasr_sincos u_az_trig (
    .clk     (clk),
    .angle   (xa_2),
    .sin_val (ps),
    .cos_val (pc)
  );

  rasr_sincos u_rot_trig (
    .clk     (clk),
    .angle   (alpha_2),
    .sin_val (sa),
    .cos_val (ca)
  );

  // stage 29: unfold the quadrant, scale by the polar sine
  assign ps_s = $signed({1'b0, ps});
  assign pc_s = $signed({2'b00, pc});

  always_comb begin
    unique case (quad_st[28])
      QUAD_1: begin
        cphi = pc_s;
        sphi = ps_s;
      end
      QUAD_2: begin
        cphi = -ps_s;
        sphi = pc_s;
      end
      QUAD_3: begin
        cphi = -pc_s;
        sphi = -ps_s;
      end
      QUAD_4: begin
        cphi = ps_s;
        sphi = -pc_s;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    kxp        <= $signed({1'b0, sint_st[28]}) * cphi;
    kyp        <= $signed({1'b0, sint_st[28]}) * sphi;
    sa_st[29]  <= sa;
    ca_st[29]  <= ca;
    omc_st[29] <= (ca >= ONE_Q30) ? '0 : ONE_Q30 - ca;
    for (int i = 30; i <= 33; i++) begin
      sa_st[i] <= sa_st[i-1];
      ca_st[i] <= ca_st[i-1];
    end
    for (int i = 30; i <= 35; i++) omc_st[i] <= omc_st[i-1];
  end

  // stage 30: axis vector in Q2.30
  assign kx_r = round_shift(72'(kxp), 14);
  assign ky_r = round_shift(72'(kyp), 14);

  always_ff @(posedge clk) begin
    k_st[30][0] <= kx_r[31:0];
    k_st[30][1] <= ky_r[31:0];
    k_st[30][2] <= {u_st[29], 16'h0000};
    for (int i = 31; i <= 33; i++) k_st[i] <= k_st[i-1];
  end

  // stage 31: all products k[a] * s[b]
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        kp[a][b] <= k_st[30][a] * sp_st[30][b];
      end
    end
  end

  // stage 32: dot and cross sums
  always_ff @(posedge clk) begin
    dsum  <= kp[0][0] + kp[1][1] + kp[2][2];
    cs[0] <= kp[1][2] - kp[2][1];
    cs[1] <= kp[2][0] - kp[0][2];
    cs[2] <= kp[0][1] - kp[1][0];
  end

  // stage 33: round dot and cross to Q2.30
  always_comb begin
    dot_r = round_shift(72'(dsum), 14);
    for (int i = 0; i < 3; i++) cr_r[i] = round_shift(72'(cs[i]), 14);
  end

  always_ff @(posedge clk) begin
    dot_33 <= dot_r[33:0];
    for (int i = 0; i < 3; i++) cr_33[i] <= cr_r[i][33:0];
  end

  // stages 34..37: the three Rodrigues terms
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      t1_st[34][i] <= $signed({1'b0, ca_st[33]}) * sp_st[33][i];
      t2p[i]       <= $signed({1'b0, sa_st[33]}) * cr_33[i];
      kdp[i]       <= k_st[33][i] * dot_33;
    end
    for (int i = 35; i <= 37; i++) t1_st[i] <= t1_st[i-1];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t2_r[i] = round_shift(72'(t2p[i]), 16);
      kd_r[i] = round_shift(72'(kdp[i]), 30);
      t3_r[i] = round_shift(72'(t3p[i]), 16);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      t2_st[35][i] <= t2_r[i][49:0];
      kd_35[i]     <= kd_r[i][33:0];
      t3p[i]       <= kd_35[i] * $signed({1'b0, omc_st[35]});
      t3_37[i]     <= t3_r[i][49:0];
    end
    for (int i = 36; i <= 37; i++) t2_st[i] <= t2_st[i-1];
  end

  // stage 38: sum in Q.44
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sum_38[i] <= t1_st[37][i] + t2_st[37][i] + t3_37[i];
    end
  end

  // stage 39: round to Q2.14 and saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fin_r[i] = round_shift(72'(sum_38[i]), 30);
      if (fin_r[i] > SAT_HI) begin
        sat_v[i] = 16'sh7fff;
      end else if (fin_r[i] < SAT_LO) begin
        sat_v[i] = -16'sh8000;
      end else begin
        sat_v[i] = fin_r[i][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    result.rotated_x <= sat_v[0];
    result.rotated_y <= sat_v[1];
    result.rotated_z <= sat_v[2];
  end

endmodule

`default_nettype wire
